>>> design/sfp_pkg.sv
// sfp_pkg: shared types and frame layout constants for the sample packet framer.
// No dependencies.
package sfp_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [5:0]  fill_t;
    typedef logic [7:0]  frame_num_t;
    typedef logic [15:0] sum_t;

    typedef struct packed {
        logic       wide;
        frame_num_t number;
        sum_t       sum;
    } frame_info_t;

    localparam int WIDE_PER_FRAME   = 25;
    localparam int NARROW_PER_FRAME = 50;
    localparam int PAYLOAD_BYTES    = 50;
    localparam int FRAME_BYTES      = 56;

    localparam byte_t FRAME_START_CODE = 8'd100;
    localparam byte_t FRAME_STOP_CODE  = 8'd101;
    localparam byte_t MODE_WIDE_CODE   = 8'd89;
    localparam byte_t MODE_NARROW_CODE = 8'd88;

    localparam fill_t POS_START    = 6'd0;
    localparam fill_t POS_MODE     = 6'd1;
    localparam fill_t POS_NUMBER   = 6'd2;
    localparam fill_t POS_PAYLOAD  = 6'd3;
    localparam fill_t POS_PAY_LAST = 6'd52;
    localparam fill_t POS_SUM_HI   = 6'd53;
    localparam fill_t POS_SUM_LO   = 6'd54;
    localparam fill_t POS_STOP     = 6'd55;

    localparam fill_t LAST_PAYLOAD_ADDR = 6'(PAYLOAD_BYTES - 1);

endpackage

>>> design/sample_packet_framer_unit.sv
// sample_packet_framer_unit: top level; sample intake, counters and frame sequencing.
// Depends on sfp_pkg, sfp_payload_ram, sfp_frame_tx.
//
// Input channel: sample_valid/sample_ready carry one 16-bit sample per word.
// Output channel: frame_valid/frame_ready carry one frame byte per word, with
// frame_end high on the closing byte. Each full payload yields a 56-byte frame.
// Intake: a narrow-mode sample stores one byte, a wide-mode sample two (high,
// then low; intake held) via the store's single write port (one byte per cycle).
// A frame's first byte passes the tx issue counter, s1 stage and output register
// after the store takes the last payload byte; intake is held until the closing
// byte is taken.
// Samples past the last whole frame of a burst are counted and dropped.
// cfg_wr_en writes the mode bit and clears fill, frame index and byte sum.
// Reset: counters cleared, narrow mode, no frame pending; payload store is not
// cleared. When the receiver stalls, the output byte holds and intake stays
// held until the frame has gone out completely.
module sample_packet_framer_unit
    import sfp_pkg::*;
#(
    parameter int BUFFER_SAMPLES = 1000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [15:0] sample_value,
    output logic        frame_valid,
    input  logic        frame_ready,
    output logic [7:0]  frame_byte,
    output logic        frame_end
);

    localparam int FRAMES_WIDE   = BUFFER_SAMPLES / WIDE_PER_FRAME;
    localparam int FRAMES_NARROW = BUFFER_SAMPLES / NARROW_PER_FRAME;
    localparam int TAIL_WIDE     = BUFFER_SAMPLES - FRAMES_WIDE * WIDE_PER_FRAME;
    localparam int TAIL_NARROW   = BUFFER_SAMPLES - FRAMES_NARROW * NARROW_PER_FRAME;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOW  = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       wide_reg, wide_next;
    fill_t      fill_reg, fill_next;
    frame_num_t number_reg, number_next;
    sum_t       sum_reg, sum_next;
    byte_t      low_reg;

    frame_num_t  frames_sel;
    fill_t       tail_sel;
    logic        accept;
    logic        in_tail;
    fill_t       fill_inc;
    frame_num_t  number_inc;
    logic        wr_en;
    byte_t       wr_data;
    logic        tx_start;
    logic        tx_done;
    logic        rd_en;
    fill_t       rd_addr;
    byte_t       rd_data;
    frame_info_t info;

    assign frames_sel = wide_reg ? frame_num_t'(FRAMES_WIDE) : frame_num_t'(FRAMES_NARROW);
    assign tail_sel   = wide_reg ? fill_t'(TAIL_WIDE) : fill_t'(TAIL_NARROW);

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign in_tail      = (number_reg == frames_sel);
    assign fill_inc     = fill_reg + 6'd1;
    assign number_inc   = number_reg + 8'd1;

    assign wr_en   = (accept && !in_tail) || (state_reg == ST_LOW);
    assign wr_data = (state_reg == ST_LOW) ? low_reg :
                     (wide_reg ? sample_value[15:8] : sample_value[7:0]);

    always_comb
    begin
        state_next  = state_reg;
        wide_next   = wide_reg;
        fill_next   = fill_reg;
        number_next = number_reg;
        sum_next    = sum_reg;
        tx_start    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_tail)
                    begin
                        fill_next = fill_inc;
                        if (fill_inc >= tail_sel)
                        begin
                            fill_next   = '0;
                            number_next = '0;
                        end
                    end
                    else
                    begin
                        fill_next = fill_inc;
                        sum_next  = sum_reg + sum_t'(wr_data);
                        if (wide_reg)
                        begin
                            state_next = ST_LOW;
                        end
                        else if (fill_reg == LAST_PAYLOAD_ADDR)
                        begin
                            state_next = ST_SEND;
                            tx_start   = 1'b1;
                        end
                    end
                end
            end
            ST_LOW:
            begin
                fill_next  = fill_inc;
                sum_next   = sum_reg + sum_t'(low_reg);
                state_next = ST_IDLE;
                if (fill_reg == LAST_PAYLOAD_ADDR)
                begin
                    state_next = ST_SEND;
                    tx_start   = 1'b1;
                end
            end
            ST_SEND:
            begin
                if (tx_done)
                begin
                    state_next  = ST_IDLE;
                    fill_next   = '0;
                    sum_next    = '0;
                    number_next = number_inc;
                    if (number_inc == frames_sel && tail_sel == '0)
                    begin
                        number_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr_en)
        begin
            wide_next   = cfg_wr_data;
            fill_next   = '0;
            number_next = '0;
            sum_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wide_reg   <= 1'b0;
            fill_reg   <= '0;
            number_reg <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wide_reg   <= wide_next;
            fill_reg   <= fill_next;
            number_reg <= number_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            low_reg <= sample_value[7:0];
        end
    end

    assign info.wide   = wide_reg;
    assign info.number = number_reg;
    assign info.sum    = sum_reg;

    sfp_payload_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfp_frame_tx u_tx (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (tx_start),
        .info        (info),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end),
        .done        (tx_done)
    );

endmodule

>>> design/sfp_payload_ram.sv
// sfp_payload_ram: 50 x 8 payload store, one write port, one registered read port.
// Depends on sfp_pkg.
module sfp_payload_ram
    import sfp_pkg::*;
(
    input  logic  clk,
    input  logic  wr_en,
    input  fill_t wr_addr,
    input  byte_t wr_data,
    input  logic  rd_en,
    input  fill_t rd_addr,
    output byte_t rd_data
);

    byte_t mem [PAYLOAD_BYTES];
    byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/sfp_frame_tx.sv
// sfp_frame_tx: walks the 56 byte positions of a frame, reads the payload store
// ahead of the s1 stage and drives the output register. Depends on sfp_pkg.
module sfp_frame_tx
    import sfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  frame_info_t info,
    output logic        rd_en,
    output fill_t       rd_addr,
    input  byte_t       rd_data,
    output logic        frame_valid,
    input  logic        frame_ready,
    output byte_t       frame_byte,
    output logic        frame_end,
    output logic        done
);

    fill_t issue_cnt_reg, issue_cnt_next;
    logic  issuing_reg, issuing_next;
    logic  s1_valid_reg, s1_valid_next;
    fill_t s1_idx_reg, s1_idx_next;
    logic  out_valid_reg, out_valid_next;
    byte_t out_byte_reg, out_byte_next;
    logic  out_end_reg, out_end_next;
    logic  advance;
    byte_t s1_byte;

    assign advance = !out_valid_reg || frame_ready;
    assign rd_en   = advance && issuing_reg &&
                     (issue_cnt_reg >= POS_PAYLOAD) && (issue_cnt_reg <= POS_PAY_LAST);
    assign rd_addr = issue_cnt_reg - POS_PAYLOAD;

    always_comb
    begin
        case (s1_idx_reg)
            POS_START:  s1_byte = FRAME_START_CODE;
            POS_MODE:   s1_byte = info.wide ? MODE_WIDE_CODE : MODE_NARROW_CODE;
            POS_NUMBER: s1_byte = info.number;
            POS_SUM_HI: s1_byte = info.sum[15:8];
            POS_SUM_LO: s1_byte = info.sum[7:0];
            POS_STOP:   s1_byte = FRAME_STOP_CODE;
            default:    s1_byte = rd_data;
        endcase
    end

    always_comb
    begin
        issue_cnt_next = issue_cnt_reg;
        issuing_next   = issuing_reg;
        s1_valid_next  = s1_valid_reg;
        s1_idx_next    = s1_idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        if (start)
        begin
            issue_cnt_next = POS_START;
            issuing_next   = 1'b1;
            s1_valid_next  = 1'b0;
        end
        else if (advance)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_byte_next = s1_byte;
                out_end_next  = (s1_idx_reg == POS_STOP);
            end
            s1_valid_next = issuing_reg;
            s1_idx_next   = issue_cnt_reg;
            if (issuing_reg)
            begin
                issue_cnt_next = issue_cnt_reg + 6'd1;
                if (issue_cnt_reg == POS_STOP)
                begin
                    issuing_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= POS_START;
            issuing_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_idx_reg    <= POS_START;
            out_valid_reg <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            issue_cnt_reg <= issue_cnt_next;
            issuing_reg   <= issuing_next;
            s1_valid_reg  <= s1_valid_next;
            s1_idx_reg    <= s1_idx_next;
            out_valid_reg <= out_valid_next;
            out_end_reg   <= out_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    assign frame_valid = out_valid_reg;
    assign frame_byte  = out_byte_reg;
    assign frame_end   = out_end_reg;
    assign done        = out_valid_reg && frame_ready && out_end_reg;

endmodule
